// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check under reset: disabled while rst is low
`define CHK_RST(lbl, clk, rst, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst) (prop)) else $error(msg);

// check at every edge, reset included
`define CHK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CHK_RST(lbl, clk, rst, prop, msg)
`define CHK_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- sv/dpf_pkg.sv -----
// ----------------------------------------------------------------------------
// dpf_pkg
// shared types and constants of the demand paging fault engine
// ----------------------------------------------------------------------------
package dpf_pkg;

    localparam int DIR_ENTRIES    = 1024;
    localparam int TABLE_ENTRIES  = 1024;
    localparam int FREE_DEPTH_DEF = 1024;

    localparam int PAGE_SHIFT  = 12;
    localparam int VPN_W       = 32 - PAGE_SHIFT;
    localparam int FRAME_W     = 20;
    localparam int ENTRY_IDX_W = $clog2(TABLE_ENTRIES);
    localparam int DIR_IDX_W   = $clog2(DIR_ENTRIES);
    localparam int NPAGES      = DIR_ENTRIES * TABLE_ENTRIES;

    // written flags are kept 32 to a row
    localparam int ROW_BIT_W     = 5;
    localparam int ROW_IDX_W     = VPN_W - ROW_BIT_W;
    localparam int ROWS_PER_TBL  = TABLE_ENTRIES / (2 ** ROW_BIT_W);
    localparam int ROW_SEL_W     = $clog2(ROWS_PER_TBL);

    localparam int START_W    = 20;
    localparam int COUNT_W    = 21;
    localparam int CFG_DATA_W = 21;
    localparam int CFG_IDX_W  = 1;

    localparam logic [31:0] PAGE_MASK = 32'hFFFF_F000;
    localparam logic [31:0] DIR_FLAGS = 32'h0000_0007;
    localparam logic [31:0] USER_LOW  = 32'h8000_0000;
    localparam logic [31:0] USER_HIGH = 32'hF000_0000;
    localparam logic [31:0] PTE_P     = 32'h0000_0001;
    localparam logic [31:0] PTE_RW    = 32'h0000_0002;
    localparam logic [31:0] PTE_US    = 32'h0000_0004;

    typedef enum logic [1:0] {
        OP_FAULT = 2'd0,
        OP_FREE  = 2'd1,
        OP_MAP   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_NOMEM   = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_START = 1'b0,
        REG_FRAME_COUNT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] address;
        logic [31:0] phys_addr;
        logic        for_user;
        logic        for_write;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] entry;
        logic [31:0] data_frame;
        logic [31:0] table_frame;
    } rsp_t;

    typedef struct packed {
        logic take;
        logic push;
    } alloc_cmd_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] frame;
    } alloc_rsp_t;

    typedef struct packed {
        logic                 dir_rd;
        logic                 dir_wr;
        logic                 pte_rd;
        logic                 pte_wr;
        logic                 row_clr;
        logic [ROW_SEL_W-1:0] row_sel;
    } store_cmd_t;

endpackage

// ----- sv/dpf_frame_alloc.sv -----
// ----------------------------------------------------------------------------
// dpf_frame_alloc
// frame allocator: lifo stack of freed frames, then a bump pointer over
// the configured frame range; a take returns its frame from a register, in the cycle after the take and not later
// ----------------------------------------------------------------------------
module dpf_frame_alloc
    import dpf_pkg::*;
#(
    parameter int FREE_DEPTH = FREE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  alloc_cmd_t            cmd,
    input  logic [FRAME_W-1:0]    push_frame,
    output alloc_rsp_t            result
);

    localparam int FC_W = $clog2(FREE_DEPTH + 1);
    localparam int SA_W = $clog2(FREE_DEPTH);

    logic [FRAME_W-1:0] stack_mem [FREE_DEPTH];
    logic [FRAME_W-1:0] stack_rdata_reg;

    logic [START_W-1:0] frame_start_reg;
    logic [COUNT_W-1:0] frame_count_reg;
    logic [COUNT_W-1:0] bump_offset_reg;
    logic [FC_W-1:0]    free_count_reg;
    logic [FRAME_W-1:0] bump_frame_reg;
    logic               popped_reg;
    logic               ok_reg;

    logic               can_pop;
    logic               can_push;
    logic               bump_ok;
    logic [SA_W-1:0]    pop_idx;
    logic [SA_W-1:0]    push_idx;
    logic [FRAME_W-1:0] bump_frame;

    assign can_pop    = (free_count_reg != '0);
    assign can_push   = (free_count_reg < FC_W'(FREE_DEPTH));
    assign bump_ok    = (bump_offset_reg < frame_count_reg);
    assign pop_idx    = SA_W'(free_count_reg - FC_W'(1));
    assign push_idx   = free_count_reg[SA_W-1:0];
    // frame number wraps at 20 bits
    assign bump_frame = frame_start_reg + bump_offset_reg[FRAME_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_start_reg <= '0;
            frame_count_reg <= '0;
            bump_offset_reg <= '0;
            free_count_reg  <= '0;
            bump_frame_reg  <= '0;
            popped_reg      <= 1'b0;
            ok_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_START: frame_start_reg <= cfg_data[START_W-1:0];
                    REG_FRAME_COUNT: frame_count_reg <= cfg_data[COUNT_W-1:0];
                    default:         ;
                endcase
            end
            if (cmd.take)
            begin
                if (can_pop)
                begin
                    free_count_reg <= free_count_reg - FC_W'(1);
                    popped_reg     <= 1'b1;
                    ok_reg         <= 1'b1;
                end
                else if (bump_ok)
                begin
                    bump_frame_reg  <= bump_frame;
                    bump_offset_reg <= bump_offset_reg + COUNT_W'(1);
                    popped_reg      <= 1'b0;
                    ok_reg          <= 1'b1;
                end
                else
                begin
                    popped_reg <= 1'b0;
                    ok_reg     <= 1'b0;
                end
            end
            else if (cmd.push && can_push)
            begin
                free_count_reg <= free_count_reg + FC_W'(1);
            end
        end
    end

    // freed frames beyond the stack depth are dropped
    always_ff @(posedge clk)
    begin
        if (cmd.push && can_push)
        begin
            stack_mem[push_idx] <= push_frame;
        end
        if (cmd.take && can_pop)
        begin
            stack_rdata_reg <= stack_mem[pop_idx];
        end
    end

    assign result.ok    = ok_reg;
    assign result.frame = {(popped_reg ? stack_rdata_reg : bump_frame_reg),
                           {PAGE_SHIFT{1'b0}}};

endmodule

// ----- sv/dpf_page_store.sv -----
// ----------------------------------------------------------------------------
// dpf_page_store
// page directory, page table entries and per-entry written flags, all in
// synchronous memories; directory is cleared by a sweep after reset
// ----------------------------------------------------------------------------
module dpf_page_store
    import dpf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  store_cmd_t       cmd,
    input  logic [VPN_W-1:0] vpn,
    input  logic [31:0]      dir_wdata,
    input  logic [31:0]      pte_wdata,
    output logic [31:0]      dir_rdata,
    output logic [31:0]      pte_rdata,
    output logic             ready
);

    logic [31:0] dir_mem [DIR_ENTRIES];
    logic [31:0] tbl_mem [NPAGES];
    logic [31:0] wflag_mem [2 ** ROW_IDX_W];

    logic [31:0]          dir_rdata_reg;
    logic [31:0]          tbl_rdata_reg;
    logic [31:0]          wflag_rdata_reg;
    logic [ROW_BIT_W-1:0] bit_sel_reg;

    logic [DIR_IDX_W-1:0] clr_cnt_reg;
    logic                 clr_done_reg;

    logic [DIR_IDX_W-1:0] dir_idx;
    logic [ROW_IDX_W-1:0] row_idx;
    logic [ROW_BIT_W-1:0] row_bit;
    logic [ROW_IDX_W-1:0] clr_row;

    assign dir_idx = vpn[VPN_W-1 -: DIR_IDX_W];
    assign row_idx = vpn[VPN_W-1:ROW_BIT_W];
    assign row_bit = vpn[ROW_BIT_W-1:0];
    assign clr_row = {dir_idx, cmd.row_sel};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_done_reg <= 1'b0;
        end
        else if (!clr_done_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + DIR_IDX_W'(1);
            if (clr_cnt_reg == {DIR_IDX_W{1'b1}})
            begin
                clr_done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!clr_done_reg)
        begin
            dir_mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.dir_wr)
        begin
            dir_mem[dir_idx] <= dir_wdata;
        end
        if (cmd.dir_rd)
        begin
            dir_rdata_reg <= dir_mem[dir_idx];
        end
    end

    // flag row write reuses the row fetched by the preceding entry read
    always_ff @(posedge clk)
    begin
        if (cmd.pte_wr)
        begin
            tbl_mem[vpn] <= pte_wdata;
        end
        if (cmd.row_clr)
        begin
            wflag_mem[clr_row] <= '0;
        end
        else if (cmd.pte_wr)
        begin
            wflag_mem[row_idx] <= wflag_rdata_reg | (32'd1 << row_bit);
        end
        if (cmd.pte_rd)
        begin
            tbl_rdata_reg   <= tbl_mem[vpn];
            wflag_rdata_reg <= wflag_mem[row_idx];
            bit_sel_reg     <= row_bit;
        end
    end

    assign dir_rdata = dir_rdata_reg;
    assign pte_rdata = wflag_rdata_reg[bit_sel_reg] ? tbl_rdata_reg : '0;
    assign ready     = clr_done_reg;

endmodule

// ----- sv/demand_paging_fault_engine_unit.sv -----
// ----------------------------------------------------------------------------
// demand_paging_fault_engine_unit
// two-level page table fault handler with a frame allocator
// ----------------------------------------------------------------------------
// One request at a time. A fault or map whose page table is present goes from
// accept through a directory read, an entry read and the result; a fault that
// allocates a data frame adds an allocation step. Allocating a page table adds
// an allocation step, a sweep that clears the new table's written-flag rows,
// one row per cycle, and an entry re-read. A free pushes its frame before the
// result and an unused opcode goes straight to the result. After reset the
// directory memory is cleared one entry per cycle, during which no request is
// accepted; configuration writes are taken at any time. A new request is taken
// while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module demand_paging_fault_engine_unit
    import dpf_pkg::*;
#(
    parameter int FREE_DEPTH = FREE_DEPTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FREE,
        S_DIR,
        S_TALLOC,
        S_SWEEP,
        S_PTE_RD,
        S_PTE,
        S_DALLOC,
        S_RESP
    } state_t;

    state_t               state_reg, state_next;
    req_t                 req_reg, req_next;
    logic [1:0]           status_reg, status_next;
    logic [31:0]          entry_reg, entry_next;
    logic [31:0]          dframe_reg, dframe_next;
    logic [31:0]          tframe_reg, tframe_next;
    logic [31:0]          pte_reg, pte_next;
    logic [ROW_SEL_W-1:0] sweep_reg, sweep_next;
    rsp_t                 rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    alloc_cmd_t  a_cmd;
    alloc_rsp_t  a_rsp;
    store_cmd_t  s_cmd;
    logic [VPN_W-1:0] vpn;
    logic [31:0] dir_wdata;
    logic [31:0] pte_wdata;
    logic [31:0] dir_rdata;
    logic [31:0] pte_rdata;
    logic        store_ready;

    logic [31:0] va;
    logic        user_page;
    logic [31:0] fault_pte;
    logic [31:0] map_pte;

    assign req_ready = (state_reg == S_IDLE) && store_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // directory read is issued in the accept cycle, straight from the request
    assign vpn = (state_reg == S_IDLE) ? req.address[31:PAGE_SHIFT]
                                       : req_reg.address[31:PAGE_SHIFT];

    assign va        = req_reg.address & PAGE_MASK;
    assign user_page = (va >= USER_LOW) && (va < USER_HIGH);
    assign fault_pte = (a_rsp.frame & PAGE_MASK) | (user_page ? PTE_US : '0)
                       | PTE_RW | PTE_P;
    assign map_pte   = (req_reg.phys_addr & PAGE_MASK)
                       | (req_reg.for_user ? PTE_US : '0)
                       | (req_reg.for_write ? PTE_RW : '0) | PTE_P;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        status_next    = status_reg;
        entry_next     = entry_reg;
        dframe_next    = dframe_reg;
        tframe_next    = tframe_reg;
        pte_next       = pte_reg;
        sweep_next     = sweep_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        a_cmd          = '0;
        s_cmd          = '0;
        s_cmd.row_sel  = sweep_reg;
        dir_wdata      = (a_rsp.frame & PAGE_MASK) | DIR_FLAGS;
        pte_wdata      = fault_pte;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    req_next    = req;
                    status_next = ST_DONE;
                    entry_next  = '0;
                    dframe_next = '0;
                    tframe_next = '0;
                    case (req.opcode)
                        OP_FAULT, OP_MAP:
                        begin
                            s_cmd.dir_rd = 1'b1;
                            state_next   = S_DIR;
                        end
                        OP_FREE:  state_next = S_FREE;
                        default:  state_next = S_RESP;
                    endcase
                end
            end
            S_FREE:
            begin
                a_cmd.push = 1'b1;
                state_next = S_RESP;
            end
            S_DIR:
            begin
                if ((dir_rdata & PTE_P) != '0)
                begin
                    s_cmd.pte_rd = 1'b1;
                    state_next   = S_PTE;
                end
                else
                begin
                    a_cmd.take = 1'b1;
                    state_next = S_TALLOC;
                end
            end
            S_TALLOC:
            begin
                // a missing table means every entry of it is still unwritten
                if (a_rsp.ok)
                begin
                    s_cmd.dir_wr = 1'b1;
                    tframe_next  = a_rsp.frame;
                    sweep_next   = '0;
                    state_next   = S_SWEEP;
                end
                else
                begin
                    status_next = ST_NOMEM;
                    entry_next  = '0;
                    state_next  = S_RESP;
                end
            end
            S_SWEEP:
            begin
                s_cmd.row_clr = 1'b1;
                sweep_next    = sweep_reg + ROW_SEL_W'(1);
                if (sweep_reg == {ROW_SEL_W{1'b1}})
                begin
                    state_next = S_PTE_RD;
                end
            end
            S_PTE_RD:
            begin
                s_cmd.pte_rd = 1'b1;
                state_next   = S_PTE;
            end
            S_PTE:
            begin
                pte_next = pte_rdata;
                if ((pte_rdata & PTE_P) != '0)
                begin
                    status_next = ST_PRESENT;
                    entry_next  = pte_rdata;
                    state_next  = S_RESP;
                end
                else if (req_reg.opcode == OP_FAULT)
                begin
                    a_cmd.take = 1'b1;
                    state_next = S_DALLOC;
                end
                else
                begin
                    s_cmd.pte_wr = 1'b1;
                    pte_wdata    = map_pte;
                    entry_next   = map_pte;
                    state_next   = S_RESP;
                end
            end
            S_DALLOC:
            begin
                if (a_rsp.ok)
                begin
                    s_cmd.pte_wr = 1'b1;
                    entry_next   = fault_pte;
                    dframe_next  = a_rsp.frame;
                end
                else
                begin
                    status_next = ST_NOMEM;
                    entry_next  = pte_reg;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status      = status_reg;
                    rsp_next.entry       = entry_reg;
                    rsp_next.data_frame  = dframe_reg;
                    rsp_next.table_frame = tframe_reg;
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            req_reg       <= '0;
            status_reg    <= ST_DONE;
            entry_reg     <= '0;
            dframe_reg    <= '0;
            tframe_reg    <= '0;
            pte_reg       <= '0;
            sweep_reg     <= '0;
            rsp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            status_reg    <= status_next;
            entry_reg     <= entry_next;
            dframe_reg    <= dframe_next;
            tframe_reg    <= tframe_next;
            pte_reg       <= pte_next;
            sweep_reg     <= sweep_next;
            rsp_reg       <= rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    dpf_frame_alloc #(
        .FREE_DEPTH (FREE_DEPTH)
    ) u_alloc (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (a_cmd),
        .push_frame (req_reg.address[31:PAGE_SHIFT]),
        .result     (a_rsp)
    );

    dpf_page_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (s_cmd),
        .vpn       (vpn),
        .dir_wdata (dir_wdata),
        .pte_wdata (pte_wdata),
        .dir_rdata (dir_rdata),
        .pte_rdata (pte_rdata),
        .ready     (store_ready)
    );

    // a present entry is never reported together with a fresh allocation
    `CHK_RST(a_present_no_alloc, clk, rst_n,
        (rsp_valid && rsp.status == ST_PRESENT)
            |-> (rsp.entry[0] && rsp.data_frame == '0 && rsp.table_frame == '0),
        "present entry with allocation")
    // out of frames never leaves a data frame behind
    `CHK_RST(a_nomem_no_data, clk, rst_n,
        (rsp_valid && rsp.status == ST_NOMEM) |-> (rsp.data_frame == '0 && !rsp.entry[0]),
        "out of frames with data frame")
    // a new result is only loaded once the previous one is gone
    `CHK_RST(a_rsp_no_overrun, clk, rst_n,
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp)),
        "result overwritten while stalled")
    // no request is taken while the directory is still being cleared
    `CHK_ALWAYS(a_no_req_in_clear, clk, (!store_ready) |-> (!req_ready),
        "request accepted during clear")

endmodule
